// ----- rtl/mlp3_pkg.sv -----
// Shared types, constants and fixed-point helpers for the three-layer MLP block.
package mlp3_pkg;

  localparam int ADDR_W = 21;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;
  localparam int PRED_W = 15;
  localparam int FRAC   = 11;

  localparam logic signed [VAL_W-1:0] Q_ONE = 16'sd2048;
  localparam logic [ACC_W:0]          RND   = 41'd1024;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FEAT = 1'b1;

  // Operation kinds carried down the MAC pipeline
  localparam logic [2:0] K_SUM  = 3'd0;  // layer-one sum update, write back
  localparam logic [2:0] K_B1   = 3'd1;  // layer-one bias, finish, write z1
  localparam logic [2:0] K_ACC0 = 3'd2;  // first term of a dot product
  localparam logic [2:0] K_ACC  = 3'd3;  // further term
  localparam logic [2:0] K_FIN2 = 3'd4;  // layer-two bias, finish to z2
  localparam logic [2:0] K_FIN3 = 3'd5;  // output bias, finish to prediction

  typedef struct packed {
    logic signed [ACC_W-1:0] v;
    logic                    ovf;
  } acc_sat_t;

  typedef struct packed {
    logic [PRED_W-1:0] q;
    logic              clip;
  } fin_t;

  function automatic acc_sat_t acc_add(input logic signed [ACC_W-1:0] b,
                                       input logic signed [PROD_W-1:0] p);
    logic signed [ACC_W:0] s;
    acc_sat_t r;
    s = {b[ACC_W-1], b} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
    r.ovf = s[ACC_W] ^ s[ACC_W-1];
    if (r.ovf) begin
      r.v = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r.v = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // Q17.22 to Q4.11: round half up, ReLU, clip
  function automatic fin_t unit_finish(input logic signed [ACC_W-1:0] a);
    logic [ACC_W:0] r;
    fin_t f;
    r = {a[ACC_W-1], a} + RND;
    f.q = '0;
    f.clip = 1'b0;
    if (!r[ACC_W] && (r != '0)) begin
      if (|r[ACC_W-1:FRAC+PRED_W]) begin
        f.q = '1;
        f.clip = 1'b1;
      end else begin
        f.q = r[FRAC+PRED_W-1:FRAC];
      end
    end
    return f;
  endfunction

endpackage

// ----- rtl/mlp_three_layer_relu_inference.sv -----
// Top level: three-layer ReLU MLP with a shared MAC around weight and sum memories.
//
// Load transactions (cmd 0) write one weight word. A feature transaction is
// accepted, then issues one weight read per cycle from the single-port weight
// memory feeding one shared multiply-accumulate; the read/multiply/accumulate
// pipeline then drains before the next item is taken. A feature with
// last_feature set then adds the layer-one biases, layer two, the output unit
// and the load of the output register, which holds the result while new
// transactions are taken. Layer-one sums live in a small memory with a valid
// bit per entry, so no clearing pass is needed.
module mlp_three_layer_relu_inference
  import mlp3_pkg::*;
#(
  parameter int INPUT_SIZE   = 4800,
  parameter int HIDDEN_ONE   = 20,
  parameter int HIDDEN_TWO   = 4,
  parameter int WEIGHT_DEPTH = 131072
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [16:0]             in_weight_address,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_feature,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PRED_W-1:0]       out_prediction,
  output logic                    out_saturated
);

  localparam int B1BASE    = HIDDEN_ONE * INPUT_SIZE;
  localparam int B2BASE    = B1BASE + HIDDEN_ONE;
  localparam int BIAS2BASE = B2BASE + HIDDEN_TWO * HIDDEN_ONE;
  localparam int B3BASE    = BIAS2BASE + HIDDEN_TWO;
  localparam int WA  = $clog2(WEIGHT_DEPTH);
  localparam int FW  = $clog2(INPUT_SIZE + 1);
  localparam int H1W = (HIDDEN_ONE > 1) ? $clog2(HIDDEN_ONE) : 1;
  localparam int H2W = (HIDDEN_TWO > 1) ? $clog2(HIDDEN_TWO) : 1;
  localparam int IW  = (H1W > H2W) ? H1W : H2W;
  localparam int CW  = $clog2(HIDDEN_ONE + HIDDEN_TWO + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_L1    = 3'd1;
  localparam logic [2:0] S_B1    = 3'd2;
  localparam logic [2:0] S_L2    = 3'd3;
  localparam logic [2:0] S_L3    = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // memories
  logic [VAL_W-1:0]        wmem [WEIGHT_DEPTH];
  logic signed [ACC_W-1:0] smem [HIDDEN_ONE];
  logic [HIDDEN_ONE-1:0]   sv_r;

  // control
  logic [2:0]        st_r, st_nxt, ret_r, ret_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [H2W-1:0]    v_r, v_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [FW-1:0]     fi_r, fi_nxt;
  logic              clip_r;
  logic              out_valid_r;
  logic              emit;
  logic              in_acc;

  logic signed [VAL_W-1:0] feat_r;
  logic                    last_r;

  // issue
  logic                    iss_v;
  logic [2:0]              iss_kind;
  logic [IW-1:0]           iss_idx;
  logic [ADDR_W-1:0]       iss_addr;
  logic signed [VAL_W-1:0] iss_m;
  logic                    iss_use_sum;

  // stage 1
  logic                    s1_v_r;
  logic [2:0]              s1_kind_r;
  logic [IW-1:0]           s1_idx_r;
  logic signed [VAL_W-1:0] s1_m_r;
  logic                    s1_use_sum_r;
  logic                    s1_inr_r;
  logic                    s1_sv_r;
  logic signed [VAL_W-1:0] wq_r;
  logic signed [ACC_W-1:0] sq_r;
  logic signed [VAL_W-1:0] w1, m1;
  logic signed [ACC_W-1:0] sum1;

  // stage 2
  logic                     s2_v_r;
  logic [2:0]               s2_kind_r;
  logic [IW-1:0]            s2_idx_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [ACC_W-1:0]  s2_sum_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  base2;
  acc_sat_t                 sat2;
  fin_t                     fin2;
  logic                     is_fin2;

  logic [PRED_W-1:0] z2_r [HIDDEN_TWO];
  logic [PRED_W-1:0] pred_r;
  logic [PRED_W-1:0] out_pred_r;
  logic              out_sat_r;
  logic [ADDR_W-1:0] wa_ext;

  assign in_ready       = (st_r == S_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;
  assign out_saturated  = out_sat_r;
  assign wa_ext         = ADDR_W'(in_weight_address);

  // sequencer
  always_comb begin
    st_nxt      = st_r;
    ret_nxt     = ret_r;
    cnt_nxt     = cnt_r;
    v_nxt       = v_r;
    ptr_nxt     = ptr_r;
    fi_nxt      = fi_r;
    emit        = 1'b0;
    iss_v       = 1'b0;
    iss_kind    = K_SUM;
    iss_idx     = IW'(cnt_r[H1W-1:0]);
    iss_addr    = ptr_r;
    iss_m       = feat_r;
    iss_use_sum = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && (in_cmd == CMD_FEAT)) begin
          cnt_nxt = '0;
          if (fi_r < FW'(INPUT_SIZE)) begin
            st_nxt  = S_L1;
            ptr_nxt = ADDR_W'(fi_r);
          end else if (in_last_feature) begin
            st_nxt  = S_DRAIN;
            ret_nxt = S_B1;
          end
        end
      end
      S_L1: begin
        iss_v    = 1'b1;
        iss_kind = K_SUM;
        ptr_nxt  = ptr_r + ADDR_W'(INPUT_SIZE);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(HIDDEN_ONE - 1)) begin
          fi_nxt  = fi_r + 1'b1;
          cnt_nxt = '0;
          st_nxt  = S_DRAIN;
          ret_nxt = last_r ? S_B1 : S_IDLE;
        end
      end
      S_B1: begin
        iss_v    = 1'b1;
        iss_kind = K_B1;
        iss_addr = ADDR_W'(B1BASE) + ADDR_W'(cnt_r);
        iss_m    = Q_ONE;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(HIDDEN_ONE - 1)) begin
          cnt_nxt = '0;
          v_nxt   = '0;
          ptr_nxt = ADDR_W'(B2BASE);
          st_nxt  = S_DRAIN;
          ret_nxt = S_L2;
        end
      end
      S_L2: begin
        iss_v = 1'b1;
        if (cnt_r < CW'(HIDDEN_ONE)) begin
          iss_kind    = (cnt_r == '0) ? K_ACC0 : K_ACC;
          iss_use_sum = 1'b1;
          ptr_nxt     = ptr_r + 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          iss_kind = K_FIN2;
          iss_idx  = IW'(v_r);
          iss_addr = ADDR_W'(BIAS2BASE) + ADDR_W'(v_r);
          iss_m    = Q_ONE;
          cnt_nxt  = '0;
          v_nxt    = v_r + 1'b1;
          if (v_r == H2W'(HIDDEN_TWO - 1)) begin
            st_nxt  = S_DRAIN;
            ret_nxt = S_L3;
          end
        end
      end
      S_L3: begin
        iss_v = 1'b1;
        if (cnt_r < CW'(HIDDEN_TWO)) begin
          iss_kind = (cnt_r == '0) ? K_ACC0 : K_ACC;
          iss_addr = ADDR_W'(B3BASE) + ADDR_W'(cnt_r);
          iss_m    = signed'({1'b0, z2_r[cnt_r[H2W-1:0]]});
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          iss_kind = K_FIN3;
          iss_addr = ADDR_W'(B3BASE + HIDDEN_TWO);
          iss_m    = Q_ONE;
          cnt_nxt  = '0;
          st_nxt   = S_DRAIN;
          ret_nxt  = S_EMIT;
        end
      end
      S_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          st_nxt = ret_r;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit   = 1'b1;
          fi_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // stage 1: multiply
  always_comb begin
    w1   = s1_inr_r ? wq_r : '0;
    sum1 = s1_sv_r ? sq_r : '0;
    m1   = s1_use_sum_r ? sum1[VAL_W-1:0] : s1_m_r;
  end

  // stage 2: saturating accumulate, optional finish
  always_comb begin
    if ((s2_kind_r == K_SUM) || (s2_kind_r == K_B1)) begin
      base2 = s2_sum_r;
    end else if (s2_kind_r == K_ACC0) begin
      base2 = '0;
    end else begin
      base2 = acc_r;
    end
    sat2    = acc_add(base2, s2_prod_r);
    fin2    = unit_finish(sat2.v);
    is_fin2 = (s2_kind_r == K_B1) || (s2_kind_r == K_FIN2) || (s2_kind_r == K_FIN3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      v_r         <= '0;
      fi_r        <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      sv_r        <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      cnt_r  <= cnt_nxt;
      v_r    <= v_nxt;
      fi_r   <= fi_nxt;
      s1_v_r <= iss_v;
      s2_v_r <= s1_v_r;
      if (emit) begin
        clip_r <= 1'b0;
        sv_r   <= '0;
      end else if (s2_v_r) begin
        if (sat2.ovf || (is_fin2 && fin2.clip)) begin
          clip_r <= 1'b1;
        end
        if ((s2_kind_r == K_SUM) || (s2_kind_r == K_B1)) begin
          sv_r[s2_idx_r[H1W-1:0]] <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath and memories
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (in_acc) begin
      feat_r <= in_value;
      last_r <= in_last_feature;
    end
    if (in_acc && (in_cmd == CMD_LOAD) && (32'(in_weight_address) < WEIGHT_DEPTH)) begin
      wmem[wa_ext[WA-1:0]] <= in_value;
    end
    // loads are only taken while idle, so reads and writes never share a cycle
    if (iss_v) begin
      wq_r <= wmem[iss_addr[WA-1:0]];
    end
    sq_r         <= smem[iss_idx[H1W-1:0]];
    s1_sv_r      <= sv_r[iss_idx[H1W-1:0]];
    s1_inr_r     <= (32'(iss_addr) < WEIGHT_DEPTH);
    s1_kind_r    <= iss_kind;
    s1_idx_r     <= iss_idx;
    s1_m_r       <= iss_m;
    s1_use_sum_r <= iss_use_sum;

    s2_kind_r <= s1_kind_r;
    s2_idx_r  <= s1_idx_r;
    s2_prod_r <= w1 * m1;
    s2_sum_r  <= sum1;

    if (s2_v_r) begin
      case (s2_kind_r)
        K_SUM:   smem[s2_idx_r[H1W-1:0]] <= sat2.v;
        K_B1:    smem[s2_idx_r[H1W-1:0]] <= ACC_W'(fin2.q);
        K_FIN2:  z2_r[s2_idx_r[H2W-1:0]] <= fin2.q;
        K_FIN3:  pred_r <= fin2.q;
        default: acc_r <= sat2.v;
      endcase
    end
    if (emit) begin
      out_pred_r <= pred_r;
      out_sat_r  <= clip_r;
    end
  end

endmodule

// ----- rtl/mlp3_checker.sv -----
// Port-level checker for the MLP block, bound to the top level.
module mlp3_checker
  import mlp3_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_cmd,
  input logic [16:0]             in_weight_address,
  input logic signed [VAL_W-1:0] in_value,
  input logic                    in_last_feature,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [PRED_W-1:0]       out_prediction,
  input logic                    out_saturated
);

  logic [1:0] pend_r;
  logic       last_acc;
  logic       out_acc;

  assign last_acc = in_valid && in_ready && (in_cmd == CMD_FEAT) && in_last_feature;
  assign out_acc  = out_valid && out_ready;

  // last features taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (last_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !last_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prediction) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a last feature");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    last_acc |=> !in_ready)
    else $error("ready right after last feature");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_LOAD) |=> in_ready)
    else $error("load did not complete in one cycle");

endmodule

bind mlp_three_layer_relu_inference mlp3_checker u_mlp3_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the three-layer ReLU MLP inference block.
module tb;
  import mlp3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_IN  = 4800;
  localparam int N_H1  = 20;
  localparam int N_H2  = 4;
  localparam int DEPTH = 131072;

  localparam int B1_AT    = N_H1 * N_IN;
  localparam int W2_AT    = B1_AT + N_H1;
  localparam int BIAS2_AT = W2_AT + N_H2 * N_H1;
  localparam int W3_AT    = BIAS2_AT + N_H2;
  localparam int B3_AT    = W3_AT + N_H2;

  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int     STUCK_LIMIT = 4000;
  localparam int     RANDOM_ITEMS = 780;
  localparam int     MAX_VEC = 32;

  typedef struct {
    logic              cmd;
    logic [16:0]       addr;
    logic signed [15:0] val;
    logic              last;
  } net_item_t;

  typedef struct {
    logic [PRED_W-1:0] pred;
    logic              sat;
  } net_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_LOAD;
  logic [16:0] in_weight_address = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic in_last_feature = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PRED_W-1:0] out_prediction;
  logic out_saturated;

  mlp_three_layer_relu_inference #(
    .INPUT_SIZE(N_IN),
    .HIDDEN_ONE(N_H1),
    .HIDDEN_TWO(N_H2),
    .WEIGHT_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_weight_address(in_weight_address),
    .in_value(in_value),
    .in_last_feature(in_last_feature),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_prediction(out_prediction),
    .out_saturated(out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // network state mirror
  logic signed [15:0] wts [0:DEPTH-1];
  longint sums [N_H1];
  int feat_pos = 0;
  bit clipped = 1'b0;

  net_item_t pending_items[$];
  net_result_t expected_preds[$];
  net_item_t cur_item;
  bit holding = 1'b0;
  bit in_taken = 1'b0;
  int errors = 0;
  int stuck_cycles = 0;

  function automatic longint sat_add(input longint acc, input longint term);
    longint s;
    s = acc + term;
    if (s > SUM_HI) begin
      clipped = 1'b1;
      return SUM_HI;
    end
    if (s < SUM_LO) begin
      clipped = 1'b1;
      return SUM_LO;
    end
    return s;
  endfunction

  // Q17.22 -> Q4.11, round half up, ReLU, clip
  function automatic longint to_q11(input longint acc);
    longint r;
    r = acc + 1024;
    if (r <= 0) return 0;
    r = r >>> 11;
    if (r > 32767) begin
      clipped = 1'b1;
      return 32767;
    end
    return r;
  endfunction

  task automatic run_network(input net_item_t it);
    longint z1 [N_H1];
    longint z2 [N_H2];
    longint acc;
    net_result_t res;
    int u, v;
    if (it.cmd == CMD_LOAD) begin
      wts[it.addr] = it.val;
      return;
    end
    if (feat_pos < N_IN) begin
      for (u = 0; u < N_H1; u++)
        sums[u] = sat_add(sums[u], longint'(wts[u * N_IN + feat_pos]) * longint'(it.val));
      feat_pos++;
    end
    if (!it.last) return;
    for (u = 0; u < N_H1; u++) begin
      acc = sat_add(sums[u], longint'(wts[B1_AT + u]) * 2048);
      z1[u] = to_q11(acc);
    end
    for (v = 0; v < N_H2; v++) begin
      acc = 0;
      for (u = 0; u < N_H1; u++)
        acc = sat_add(acc, z1[u] * longint'(wts[W2_AT + v * N_H1 + u]));
      acc = sat_add(acc, longint'(wts[BIAS2_AT + v]) * 2048);
      z2[v] = to_q11(acc);
    end
    acc = 0;
    for (v = 0; v < N_H2; v++)
      acc = sat_add(acc, z2[v] * longint'(wts[W3_AT + v]));
    acc = sat_add(acc, longint'(wts[B3_AT]) * 2048);
    res.pred = PRED_W'(to_q11(acc));
    res.sat = clipped;
    expected_preds.insert(expected_preds.size(), res);
    for (u = 0; u < N_H1; u++) sums[u] = 0;
    feat_pos = 0;
    clipped = 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    if (errors < 100) $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_result(input logic [PRED_W-1:0] pred, input logic sat);
    net_result_t want;
    if (expected_preds.size() == 0) begin
      report_mismatch($sformatf("unexpected result pred=%0d sat=%0b", pred, sat));
      return;
    end
    want = expected_preds.pop_front();
    if (pred !== want.pred)
      report_mismatch($sformatf("prediction %0d, expected %0d", pred, want.pred));
    if (sat !== want.sat)
      report_mismatch($sformatf("saturated %0b, expected %0b", sat, want.sat));
  endtask

  // mostly small magnitudes so the layers stay in range, some extremes
  function automatic logic signed [15:0] rnd_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'(int'($urandom_range(0, 1023)) - 512);
    if (r < 90) return 16'(int'($urandom_range(0, 8191)) - 4096);
    return 16'($urandom);
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_load(input int addr, input logic signed [15:0] v, input logic lst);
    net_item_t it;
    it.cmd = CMD_LOAD;
    it.addr = 17'(addr);
    it.val = v;
    it.last = lst;
    pending_items.insert(pending_items.size(), it);
  endtask

  // address field is don't-care on features, so it gets noise
  task automatic push_feature(input logic signed [15:0] v, input logic lst);
    net_item_t it;
    it.cmd = CMD_FEAT;
    it.addr = 17'($urandom);
    it.val = v;
    it.last = lst;
    pending_items.insert(pending_items.size(), it);
  endtask

  // driver
  int gap_left = 0;
  int in_mode_left = 0;
  bit in_calm = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_mode_left == 0) begin
        in_calm = !in_calm;
        in_mode_left = $urandom_range(50, 600);
      end else begin
        in_mode_left--;
      end
      if (in_taken) begin
        in_taken = 1'b0;
        holding = 1'b0;
        gap_left = idle_len(in_calm);
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding = 1'b1;
        end
      end
      in_valid <= holding;
      in_cmd <= cur_item.cmd;
      in_weight_address <= cur_item.addr;
      in_value <= cur_item.val;
      in_last_feature <= cur_item.last;
    end
  end

  // result-side back-pressure
  int stall_left = 0;
  int out_mode_left = 0;
  bit out_calm = 1'b1;

  always @(negedge clk) begin
    if (out_mode_left == 0) begin
      out_calm = !out_calm;
      out_mode_left = $urandom_range(50, 600);
    end else begin
      out_mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = idle_len(out_calm);
    end
  end

  // monitor: input and result transactions, plus watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        run_network(cur_item);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) check_result(out_prediction, out_saturated);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("mlp_three_layer_relu_inference: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    int a, u, f, i, k, r, len, n_rand;
    for (u = 0; u < N_H1; u++) sums[u] = 0;

    // every word the network reads gets written first; vectors never run
    // past MAX_VEC features, so only that slice of layer one is loaded
    for (u = 0; u < N_H1; u++)
      for (f = 0; f < MAX_VEC; f++)
        push_load(u * N_IN + f, rnd_word(), 1'($urandom_range(0, 1)));
    for (a = B1_AT; a <= B3_AT; a++)
      push_load(a, rnd_word(), 1'($urandom_range(0, 1)));

    // directed corners
    push_load(0, -16'sd32768, 1'b0);
    push_load(N_IN, 16'sd32767, 1'b1);           // last flag on a load
    push_load(DEPTH - 1, 16'sd32767, 1'b0);      // top of store, never read
    push_load(65536, 16'sh5555, 1'b1);
    push_feature(-16'sd32768, 1'b1);             // one-feature vector, unit 0 clips
    push_feature(16'sd32767, 1'b0);
    push_feature(16'sd0, 1'b0);
    push_feature(-16'sd1, 1'b1);                 // short vector
    push_feature(16'sd0, 1'b1);                  // biases only
    push_load(B3_AT, 16'sd32767, 1'b0);
    push_load(B1_AT, 16'sd32767, 1'b0);
    push_feature(16'sd1, 1'b1);
    push_load(B3_AT, -16'sd32768, 1'b1);
    push_feature(16'sd2048, 1'b1);
    push_load(B3_AT, rnd_word(), 1'b0);
    push_load(B1_AT, rnd_word(), 1'b0);

    // random vectors with weight updates between and occasionally inside them
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          r = $urandom_range(0, 3);
          if (r == 0) a = $urandom_range(0, DEPTH - 1);
          else if (r == 1) a = $urandom_range(B1_AT, B3_AT);
          else a = $urandom_range(0, N_H1 - 1) * N_IN + $urandom_range(0, 15);
          push_load(a, rnd_word(), 1'($urandom_range(0, 1)));
          n_rand++;
        end
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, MAX_VEC) : $urandom_range(1, 16);
      for (i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 19) == 0) begin
          a = $urandom_range(0, N_H1 - 1) * N_IN + $urandom_range(0, MAX_VEC - 1);
          push_load(a, rnd_word(), 1'($urandom_range(0, 1)));
          n_rand++;
        end
        push_feature(rnd_word(), i == len - 1);
        n_rand++;
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || holding || expected_preds.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("mlp_three_layer_relu_inference: match");
    end else begin
      $display("mlp_three_layer_relu_inference: mismatch");
    end
    $finish;
  end

endmodule
